// ----- hw/rtl/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// Shell command tokenizer package
// Token kinds, error codes, scanner modes and byte classification helpers.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int SCT_LINE_BITS   = 16;
   localparam int SCT_OFFSET_BITS = 20;
   localparam int SCT_QUEUE_DEPTH = 5;

   localparam logic [4:0] KIND_EOF      = 5'd0;
   localparam logic [4:0] KIND_INT      = 5'd1;
   localparam logic [4:0] KIND_FLOAT    = 5'd2;
   localparam logic [4:0] KIND_STRING   = 5'd3;
   localparam logic [4:0] KIND_FILESIZE = 5'd4;
   localparam logic [4:0] KIND_TRUE     = 5'd5;
   localparam logic [4:0] KIND_FALSE    = 5'd6;
   localparam logic [4:0] KIND_IDENT    = 5'd7;
   localparam logic [4:0] KIND_DIDENT   = 5'd8;
   localparam logic [4:0] KIND_LET      = 5'd9;
   localparam logic [4:0] KIND_PIPE     = 5'd10;
   localparam logic [4:0] KIND_LPAREN   = 5'd11;
   localparam logic [4:0] KIND_RPAREN   = 5'd12;
   localparam logic [4:0] KIND_DOT      = 5'd13;
   localparam logic [4:0] KIND_COMMA    = 5'd14;
   localparam logic [4:0] KIND_OR       = 5'd15;
   localparam logic [4:0] KIND_AND      = 5'd16;
   localparam logic [4:0] KIND_NOT      = 5'd17;
   localparam logic [4:0] KIND_EQ       = 5'd18;
   localparam logic [4:0] KIND_NE       = 5'd19;
   localparam logic [4:0] KIND_LT       = 5'd20;
   localparam logic [4:0] KIND_GT       = 5'd21;
   localparam logic [4:0] KIND_LE       = 5'd22;
   localparam logic [4:0] KIND_GE       = 5'd23;
   localparam logic [4:0] KIND_MATCH    = 5'd24;
   localparam logic [4:0] KIND_PLUS     = 5'd25;
   localparam logic [4:0] KIND_MINUS    = 5'd26;
   localparam logic [4:0] KIND_STAR     = 5'd27;
   localparam logic [4:0] KIND_SLASH    = 5'd28;
   localparam logic [4:0] KIND_ASSIGN   = 5'd29;
   localparam logic [4:0] KIND_ERROR    = 5'd30;
   localparam logic [4:0] KIND_DATA     = 5'd31;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_CHAR      = 3'd1;
   localparam logic [2:0] ERR_UNTERM    = 3'd2;
   localparam logic [2:0] ERR_BACKSLASH = 3'd3;
   localparam logic [2:0] ERR_BANG      = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOLR  = 8'h24;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   typedef enum logic [9:0] {
      MODE_IDLE    = 10'b00_0000_0001,
      MODE_COMMENT = 10'b00_0000_0010,
      MODE_INT     = 10'b00_0000_0100,
      MODE_FRAC    = 10'b00_0000_1000,
      MODE_TAIL    = 10'b00_0001_0000,
      MODE_SUF2    = 10'b00_0010_0000,
      MODE_STR     = 10'b00_0100_0000,
      MODE_ESC     = 10'b00_1000_0000,
      MODE_WORD    = 10'b01_0000_0000,
      MODE_SKIP    = 10'b10_0000_0000
   } mode_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_wordish(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F ||
             is_digit(c) || c == CH_SLASH;
   endfunction

   function automatic logic is_joinish(input logic [7:0] c);
      return is_wordish(c) || c == CH_MINUS || c == CH_DOT;
   endfunction

   // Mode after a digit: more digits, a fraction, or the possible size suffix.
   function automatic mode_type int_next_mode(input logic [7:0] n1, input logic [7:0] n2);
      if (is_digit(n1)) begin
         return MODE_INT;
      end else if (n1 == CH_DOT && is_digit(n2)) begin
         return MODE_FRAC;
      end
      return MODE_TAIL;
   endfunction

   function automatic logic [5:0] unit_shift(input logic [7:0] c, input logic [7:0] n1);
      logic [5:0] sh;
      sh = 6'd0;
      if (n1 == 8'h62 || n1 == 8'h42) begin
         case (c)
            8'h6B, 8'h4B: sh = 6'd10;
            8'h6D, 8'h4D: sh = 6'd20;
            8'h67, 8'h47: sh = 6'd30;
            8'h74, 8'h54: sh = 6'd40;
            default:      sh = 6'd0;
         endcase
      end
      return sh;
   endfunction

   function automatic logic [7:0] esc_decode(input logic [7:0] c);
      logic [7:0] d;
      case (c)
         8'h6E:   d = CH_LF;
         8'h74:   d = CH_TAB;
         8'h72:   d = CH_CR;
         CH_ZERO: d = CH_NUL;
         default: d = c;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] kw_kind(input logic [4:0][7:0] p, input logic [2:0] cnt);
      logic [4:0] k;
      k = KIND_IDENT;
      if (cnt == 3'd3 && {p[0], p[1], p[2]} == "and") k = KIND_AND;
      if (cnt == 3'd2 && {p[0], p[1]} == "or") k = KIND_OR;
      if (cnt == 3'd3 && {p[0], p[1], p[2]} == "not") k = KIND_NOT;
      if (cnt == 3'd4 && {p[0], p[1], p[2], p[3]} == "true") k = KIND_TRUE;
      if (cnt == 3'd5 && {p[0], p[1], p[2], p[3], p[4]} == "false") k = KIND_FALSE;
      if (cnt == 3'd3 && {p[0], p[1], p[2]} == "let") k = KIND_LET;
      return k;
   endfunction

endpackage

// ----- hw/rtl/sct_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// Token record queue
// Compacting queue of token records; takes up to three records a cycle and
// presents the oldest one at a fixed output slot.
// ----------------------------------------------------------------------------
module sct_rsp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 5,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  logic [WIDTH-1:0] push_data [3],
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [WIDTH-1:0] slot_in [DEPTH];
   logic [WIDTH-1:0] shifted [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] base;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[0];
   assign pop       = out_valid && out_ready;
   assign count     = count_ff;

   always_comb begin
      base = count_ff - CNT_W'(pop);
      for (int j = 0; j < DEPTH - 1; j++) begin
         shifted[j] = pop ? slot_ff[j + 1] : slot_ff[j];
      end
      shifted[DEPTH - 1] = pop ? '0 : slot_ff[DEPTH - 1];
      for (int j = 0; j < DEPTH; j++) begin
         slot_in[j] = shifted[j];
         for (int i = 0; i < 3; i++) begin
            if (i < int'(push_count) && int'(base) + i == j) begin
               slot_in[j] = push_data[i];
            end
         end
      end
      count_in = base + CNT_W'(push_count);
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         slot_ff[j] <= slot_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/shell_command_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Shell command tokenizer
// Byte-stream lexer that turns shell-like command text into token records.
// ----------------------------------------------------------------------------
// The tokenizer takes one source byte per cycle while the record queue has
// room and, after a two-byte lookahead window fills, scans the oldest byte
// together with its two successors, so ordinary text flows at one byte per
// clock. Records leave through a five-entry queue; the input stalls whenever
// fewer than three entries are free, since one byte can close a number,
// report an error and emit EOF at once. An end marker (tlast, or a zero byte)
// first drains each byte still held in the window, then emits EOF (unless an
// error already sent one) and returns the block to its reset state.
module shell_command_tokenizer
   import sct_pkg::*;
#(
   parameter int LINE_BITS   = SCT_LINE_BITS,
   parameter int OFFSET_BITS = SCT_OFFSET_BITS,
   localparam int RSP_BITS   = 3 + 2 * LINE_BITS + 2 * OFFSET_BITS + 72,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // char_in
   input  logic                  req_tlast,   // end_of_input
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // error_code, line, column, start_offset, length, int_value, data_byte
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [4:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast    // is_last
);

   localparam int REC_W = RSP_DATA_W + 6;
   localparam int QCNT_W = $clog2(SCT_QUEUE_DEPTH + 1);
   localparam int LB = LINE_BITS;
   localparam int OB = OFFSET_BITS;

   function automatic logic [LB-1:0] bump_l(input logic [LB-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [OB-1:0] bump_o(input logic [OB-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [REC_W-1:0] make_rec(
      input logic [4:0]    kind,
      input logic [2:0]    err,
      input logic [LB-1:0] ln,
      input logic [LB-1:0] cl,
      input logic [OB-1:0] so,
      input logic [OB-1:0] len,
      input logic [63:0]   val,
      input logic [7:0]    dat,
      input logic          last
   );
      logic [RSP_DATA_W-1:0] d;
      d = '0;
      d[2:0]                   = err;
      d[3 +: LB]               = ln;
      d[3 + LB +: LB]          = cl;
      d[3 + 2 * LB +: OB]      = so;
      d[3 + 2 * LB + OB +: OB] = len;
      d[3 + 2 * LB + 2 * OB +: 64] = val;
      d[67 + 2 * LB + 2 * OB +: 8] = dat;
      return {last, kind, d};
   endfunction

   // Input register.
   logic       inv_ff;
   logic [7:0] inc_ff;
   logic       inend_ff;

   // Scanner state.
   mode_type        mode_ff, mode_in;
   logic [7:0]      win0_ff, win0_in, win1_ff, win1_in;
   logic [1:0]      fill_ff, fill_in;
   logic [LB-1:0]   line_ff, line_in, col_ff, col_in, tsc_ff, tsc_in;
   logic [OB-1:0]   off_ff, off_in, tso_ff, tso_in;
   logic [63:0]     acc_ff, acc_in;
   logic [4:0][7:0] pfx_ff, pfx_in;
   logic [2:0]      pcnt_ff, pcnt_in;
   logic            dollar_ff, dollar_in, quote_ff, quote_in, halt_ff, halt_in;

   // Per-cycle scan controls and values.
   logic          consume, take_en, final_step, start_en, word_chk, room;
   logic [7:0]    tc, tn1, tn2;
   logic [LB-1:0] line_st, col_st;
   logic [OB-1:0] off_st;
   logic [5:0]    sh;
   logic [4:0]    sym_kind, wkind;
   logic          sym_two, sym_bad;
   logic [2:0]    sym_err;

   logic [REC_W-1:0]  rec_in [3];
   logic [1:0]        nrec;
   logic [QCNT_W-1:0] q_count;
   logic [REC_W-1:0]  q_data;

   assign req_tready = !inv_ff || consume;
   assign room       = (q_count <= QCNT_W'(SCT_QUEUE_DEPTH - 3));

   // Position after the scanned byte is consumed.
   assign off_st  = bump_o(off_ff);
   assign line_st = (tc == CH_LF) ? bump_l(line_ff) : line_ff;
   assign col_st  = (tc == CH_LF) ? LB'(1) : bump_l(col_ff);

   always_comb begin
      consume    = 1'b0;
      take_en    = 1'b0;
      final_step = 1'b0;
      start_en   = 1'b0;
      word_chk   = 1'b0;
      tc  = CH_NUL;
      tn1 = CH_NUL;
      tn2 = CH_NUL;
      sh  = 6'd0;
      sym_kind = KIND_ERROR;
      sym_two  = 1'b0;
      sym_bad  = 1'b0;
      sym_err  = ERR_NONE;
      wkind    = KIND_IDENT;
      mode_in   = mode_ff;
      win0_in   = win0_ff;
      win1_in   = win1_ff;
      fill_in   = fill_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      off_in    = off_ff;
      tso_in    = tso_ff;
      tsc_in    = tsc_ff;
      acc_in    = acc_ff;
      pfx_in    = pfx_ff;
      pcnt_in   = pcnt_ff;
      dollar_in = dollar_ff;
      quote_in  = quote_ff;
      halt_in   = halt_ff;
      nrec = 2'd0;
      for (int i = 0; i < 3; i++) begin
         rec_in[i] = '0;
      end

      // Window handling and flush sequencing.
      if (inv_ff && room) begin
         if (!inend_ff) begin
            consume = 1'b1;
            if (!halt_ff) begin
               if (fill_ff == 2'd2) begin
                  take_en = 1'b1;
                  tc  = win0_ff;
                  tn1 = win1_ff;
                  tn2 = inc_ff;
                  win0_in = win1_ff;
                  win1_in = inc_ff;
               end else if (fill_ff == 2'd1) begin
                  win1_in = inc_ff;
                  fill_in = 2'd2;
               end else begin
                  win0_in = inc_ff;
                  fill_in = 2'd1;
               end
            end
         end else begin
            take_en = 1'b1;
            if (fill_ff == 2'd2) begin
               tc  = win0_ff;
               tn1 = win1_ff;
               win0_in = win1_ff;
               fill_in = 2'd1;
            end else if (fill_ff == 2'd1) begin
               tc = win0_ff;
               fill_in = 2'd0;
            end else begin
               final_step = 1'b1;
               consume    = 1'b1;
            end
         end
      end

      if (take_en && !halt_ff) begin
         if (tc != CH_NUL) begin
            line_in = line_st;
            col_in  = col_st;
            off_in  = off_st;
         end
         if (tc == CH_NUL && mode_ff != MODE_TAIL && mode_ff != MODE_STR &&
             mode_ff != MODE_ESC) begin
            mode_in = MODE_IDLE;
         end else begin
            case (mode_ff)
               MODE_COMMENT: begin
                  if (tc == CH_LF) begin
                     mode_in  = MODE_IDLE;
                     start_en = 1'b1;
                  end
               end
               MODE_TAIL: begin
                  sh = unit_shift(tc, tn1);
                  if (tc != CH_NUL && sh != 6'd0 && !is_joinish(tn2)) begin
                     acc_in  = acc_ff << sh;
                     mode_in = MODE_SUF2;
                  end else begin
                     rec_in[nrec] = make_rec(KIND_INT, ERR_NONE, line_ff, tsc_ff, tso_ff,
                                             off_ff - tso_ff, acc_ff, 8'd0, 1'b0);
                     nrec = nrec + 2'd1;
                     mode_in  = MODE_IDLE;
                     start_en = (tc != CH_NUL);
                  end
               end
               MODE_SUF2: begin
                  rec_in[nrec] = make_rec(KIND_FILESIZE, ERR_NONE, line_st, tsc_ff, tso_ff,
                                          off_st - tso_ff, acc_ff, 8'd0, 1'b0);
                  nrec = nrec + 2'd1;
                  mode_in = MODE_IDLE;
               end
               MODE_INT: begin
                  acc_in  = (acc_ff << 3) + (acc_ff << 1) + (64'(tc) - 64'd48);
                  mode_in = int_next_mode(tn1, tn2);
               end
               MODE_FRAC: begin
                  if (!is_digit(tn1)) begin
                     rec_in[nrec] = make_rec(KIND_FLOAT, ERR_NONE, line_st, tsc_ff, tso_ff,
                                             off_st - tso_ff, 64'd0, 8'd0, 1'b0);
                     nrec = nrec + 2'd1;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_WORD: begin
                  if (!dollar_ff) begin
                     if (pcnt_ff < 3'd5) pfx_in[pcnt_ff] = tc;
                     if (pcnt_ff < 3'd6) pcnt_in = pcnt_ff + 3'd1;
                  end
                  word_chk = 1'b1;
               end
               MODE_SKIP: begin
                  mode_in = MODE_IDLE;
               end
               MODE_STR: begin
                  if (tc == CH_NUL) begin
                     rec_in[nrec] = make_rec(KIND_ERROR, ERR_UNTERM, line_ff, col_ff, '0, '0,
                                             64'd0, 8'd0, 1'b0);
                     nrec = nrec + 2'd1;
                     rec_in[nrec] = make_rec(KIND_EOF, ERR_NONE, line_ff, '0, '0, '0,
                                             64'd0, 8'd0, 1'b1);
                     nrec = nrec + 2'd1;
                     halt_in = 1'b1;
                     mode_in = MODE_IDLE;
                  end else if (tc == (quote_ff ? CH_SQ : CH_DQ)) begin
                     rec_in[nrec] = make_rec(KIND_STRING, ERR_NONE, line_st, tsc_ff, tso_ff,
                                             off_st - tso_ff, 64'd0, 8'd0, 1'b0);
                     nrec = nrec + 2'd1;
                     mode_in = MODE_IDLE;
                  end else if (tc == CH_BSL && !quote_ff) begin
                     mode_in = MODE_ESC;
                  end else begin
                     rec_in[nrec] = make_rec(KIND_DATA, ERR_NONE, line_st, tsc_ff, tso_ff,
                                             '0, 64'd0, tc, 1'b0);
                     nrec = nrec + 2'd1;
                  end
               end
               MODE_ESC: begin
                  if (tc == CH_NUL) begin
                     rec_in[nrec] = make_rec(KIND_ERROR, ERR_BACKSLASH, line_ff, bump_l(col_ff),
                                             '0, '0, 64'd0, 8'd0, 1'b0);
                     nrec = nrec + 2'd1;
                     rec_in[nrec] = make_rec(KIND_EOF, ERR_NONE, line_ff, '0, '0, '0,
                                             64'd0, 8'd0, 1'b1);
                     nrec = nrec + 2'd1;
                     halt_in = 1'b1;
                     mode_in = MODE_IDLE;
                  end else begin
                     rec_in[nrec] = make_rec(KIND_DATA, ERR_NONE, line_st, tsc_ff, tso_ff,
                                             '0, 64'd0, esc_decode(tc), 1'b0);
                     nrec = nrec + 2'd1;
                     mode_in = MODE_STR;
                  end
               end
               default: begin
                  start_en = 1'b1;
               end
            endcase
         end

         // Start of a new lexeme at the scanned byte.
         if (start_en) begin
            if (tc == CH_SPACE || tc == CH_TAB || tc == CH_CR || tc == CH_LF) begin
               mode_in = MODE_IDLE;
            end else if (tc == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (is_digit(tc)) begin
               tso_in  = off_ff;
               tsc_in  = col_ff;
               acc_in  = 64'(tc) - 64'd48;
               mode_in = int_next_mode(tn1, tn2);
            end else if (tc == CH_DQ || tc == CH_SQ) begin
               tso_in    = off_ff;
               tsc_in    = col_st;
               quote_in  = (tc == CH_SQ);
               dollar_in = 1'b0;
               mode_in   = MODE_STR;
            end else if (tc == CH_DOLR) begin
               tsc_in    = col_ff;
               tso_in    = off_st;
               dollar_in = 1'b1;
               quote_in  = 1'b0;
               mode_in   = MODE_WORD;
               word_chk  = 1'b1;
            end else if (is_wordish(tc) && !(tc == CH_SLASH && !is_wordish(tn1))) begin
               tso_in    = off_ff;
               tsc_in    = col_ff;
               dollar_in = 1'b0;
               quote_in  = 1'b0;
               pfx_in[0] = tc;
               pcnt_in   = 3'd1;
               mode_in   = MODE_WORD;
               word_chk  = 1'b1;
            end else begin
               case (tc)
                  CH_PIPE:  sym_kind = KIND_PIPE;
                  CH_LPAR:  sym_kind = KIND_LPAREN;
                  CH_RPAR:  sym_kind = KIND_RPAREN;
                  CH_COMMA: sym_kind = KIND_COMMA;
                  CH_PLUS:  sym_kind = KIND_PLUS;
                  CH_STAR:  sym_kind = KIND_STAR;
                  CH_MINUS: sym_kind = KIND_MINUS;
                  CH_DOT:   sym_kind = KIND_DOT;
                  CH_SLASH: sym_kind = KIND_SLASH;
                  CH_EQ: begin
                     if (tn1 == CH_EQ) begin
                        sym_kind = KIND_EQ;
                        sym_two  = 1'b1;
                     end else if (tn1 == CH_TILDE) begin
                        sym_kind = KIND_MATCH;
                        sym_two  = 1'b1;
                     end else begin
                        sym_kind = KIND_ASSIGN;
                     end
                  end
                  CH_BANG: begin
                     if (tn1 == CH_EQ) begin
                        sym_kind = KIND_NE;
                        sym_two  = 1'b1;
                     end else begin
                        sym_bad = 1'b1;
                        sym_err = ERR_BANG;
                     end
                  end
                  CH_LT: begin
                     sym_kind = (tn1 == CH_EQ) ? KIND_LE : KIND_LT;
                     sym_two  = (tn1 == CH_EQ);
                  end
                  CH_GT: begin
                     sym_kind = (tn1 == CH_EQ) ? KIND_GE : KIND_GT;
                     sym_two  = (tn1 == CH_EQ);
                  end
                  default: begin
                     sym_bad = 1'b1;
                     sym_err = ERR_CHAR;
                  end
               endcase
               if (sym_bad) begin
                  rec_in[nrec] = make_rec(KIND_ERROR, sym_err, line_st, col_st, '0, '0,
                                          64'd0, 8'd0, 1'b0);
                  nrec = nrec + 2'd1;
                  rec_in[nrec] = make_rec(KIND_EOF, ERR_NONE, line_st, '0, '0, '0,
                                          64'd0, 8'd0, 1'b1);
                  nrec = nrec + 2'd1;
                  halt_in = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  // A two-character operator reports the offset of its second byte.
                  rec_in[nrec] = make_rec(sym_kind, ERR_NONE, line_st, col_ff,
                                          sym_two ? off_st : off_ff, OB'(1), 64'd0, 8'd0,
                                          1'b0);
                  nrec = nrec + 2'd1;
                  mode_in = sym_two ? MODE_SKIP : MODE_IDLE;
               end
            end
         end

         // A word ends unless the next byte continues it or joins another part.
         if (word_chk) begin
            if (!(is_wordish(tn1) ||
                  ((tn1 == CH_MINUS || (tn1 == CH_DOT && !dollar_in)) && is_wordish(tn2))))
            begin
               wkind = dollar_in ? KIND_DIDENT : kw_kind(pfx_in, pcnt_in);
               rec_in[nrec] = make_rec(wkind, ERR_NONE, line_st, tsc_in, tso_in,
                                       off_st - tso_in, 64'd0, 8'd0, 1'b0);
               nrec = nrec + 2'd1;
               mode_in = MODE_IDLE;
            end
         end
      end

      if (final_step) begin
         if (!halt_in) begin
            rec_in[nrec] = make_rec(KIND_EOF, ERR_NONE, line_ff, '0, '0, '0, 64'd0, 8'd0, 1'b1);
            nrec = nrec + 2'd1;
         end
         mode_in   = MODE_IDLE;
         fill_in   = 2'd0;
         line_in   = LB'(1);
         col_in    = LB'(1);
         off_in    = '0;
         tso_in    = '0;
         tsc_in    = LB'(1);
         acc_in    = 64'd0;
         pfx_in    = '0;
         pcnt_in   = 3'd0;
         dollar_in = 1'b0;
         quote_in  = 1'b0;
         halt_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         inv_ff <= 1'b1;
      end else if (consume) begin
         inv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         inc_ff   <= req_tdata;
         inend_ff <= req_tlast || (req_tdata == CH_NUL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         fill_ff   <= 2'd0;
         line_ff   <= LB'(1);
         col_ff    <= LB'(1);
         off_ff    <= '0;
         tso_ff    <= '0;
         tsc_ff    <= LB'(1);
         acc_ff    <= 64'd0;
         pfx_ff    <= '0;
         pcnt_ff   <= 3'd0;
         dollar_ff <= 1'b0;
         quote_ff  <= 1'b0;
         halt_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         fill_ff   <= fill_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         off_ff    <= off_in;
         tso_ff    <= tso_in;
         tsc_ff    <= tsc_in;
         acc_ff    <= acc_in;
         pfx_ff    <= pfx_in;
         pcnt_ff   <= pcnt_in;
         dollar_ff <= dollar_in;
         quote_ff  <= quote_in;
         halt_ff   <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      win0_ff <= win0_in;
      win1_ff <= win1_in;
   end

   sct_rsp_queue #(
      .WIDTH (REC_W),
      .DEPTH (SCT_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (nrec),
      .push_data  (rec_in),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (q_data),
      .count      (q_count)
   );

   assign rsp_tlast = q_data[REC_W-1];
   assign rsp_tuser = q_data[REC_W-2 -: 5];
   assign rsp_tdata = q_data[RSP_DATA_W-1:0];

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(SCT_QUEUE_DEPTH))
      else $error("record queue overflow");

   a_window_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("lookahead window overfilled");

   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> (mode_ff == MODE_IDLE))
      else $error("scanner active after an error");

   a_position: assert property (@(posedge clock) disable iff (reset)
      (line_ff != '0) && (col_ff != '0))
      else $error("line or column counter reached zero");
`endif

endmodule
